[sv/polygon_plane_clipper_assert.svh]
// ----------------------------------------------------------------------------
// polygon plane clipper assertion macros
// shared property wrappers on i_clk with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef POLYGON_PLANE_CLIPPER_ASSERT_SVH
`define POLYGON_PLANE_CLIPPER_ASSERT_SVH

// same-cycle implication
`define PPC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// ppc_pkg
// types, widths and helpers shared by the plane clipper modules
// ----------------------------------------------------------------------------
`default_nettype none
package ppc_pkg;

    localparam int CW = 32;           // coordinate width
    localparam int DW = 52;           // signed distance width
    localparam int NW = 53;           // divisor width (sum of two magnitudes)
    localparam int KW = 32;           // interpolation factor width
    localparam int QDEPTH = 2;        // job queue depth
    localparam int QAW = 1;           // queue pointer width

    localparam logic [2:0] CFG_NX  = 3'd0;
    localparam logic [2:0] CFG_NY  = 3'd1;
    localparam logic [2:0] CFG_NZ  = 3'd2;
    localparam logic [2:0] CFG_OFF = 3'd3;
    localparam logic [2:0] CFG_EPS = 3'd4;

    localparam logic [1:0] JOB_VERT  = 2'd0;
    localparam logic [1:0] JOB_CROSS = 2'd1;
    localparam logic [1:0] JOB_MARK  = 2'd2;

    typedef struct packed {
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic signed [17:0] nz;
        logic signed [31:0] off;
        logic        [15:0] eps;
    } t_cfg;

    typedef struct packed {
        logic [1:0]          kind;
        logic                eop;
        logic [CW-1:0]       px;
        logic [CW-1:0]       py;
        logic [CW-1:0]       pz;
        logic [CW-1:0]       qx;
        logic [CW-1:0]       qy;
        logic [CW-1:0]       qz;
        logic [DW-1:0]       num;
        logic [NW-1:0]       den;
    } t_job;

    function automatic logic [DW-1:0] f_mag(input logic signed [DW-1:0] d);
        f_mag = d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    function automatic logic f_on(input logic signed [DW-1:0] d, input logic [15:0] eps);
        logic [DW-1:0] thr;
        thr = DW'({eps, 16'h0000});
        f_on = (d == '0) || (f_mag(d) < thr);
    endfunction

    function automatic logic f_pos(input logic signed [DW-1:0] d);
        f_pos = !d[DW-1] && (d != '0);
    endfunction

    function automatic logic f_cross(input logic signed [DW-1:0] da,
                                     input logic signed [DW-1:0] db,
                                     input logic [15:0] eps);
        f_cross = !f_on(da, eps) && !f_on(db, eps) && (f_pos(da) != f_pos(db));
    endfunction

endpackage
`default_nettype wire

[sv/ppc_fifo.sv]
// ----------------------------------------------------------------------------
// ppc_fifo
// short job queue between the classifier and the clipping engine
// ----------------------------------------------------------------------------
`default_nettype none
module ppc_fifo
    import ppc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_data
);
    t_job            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QAW:0]    r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push && !o_full) - (QAW+1)'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

[sv/ppc_front.sv]
// ----------------------------------------------------------------------------
// ppc_front
// takes vertices, computes plane distance and queues the output jobs
// ----------------------------------------------------------------------------
`default_nettype none
module ppc_front
    import ppc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_cfg             i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_vertex_x,
    input  wire logic [31:0] i_vertex_y,
    input  wire logic [31:0] i_vertex_z,
    input  wire logic        i_last_vertex,
    output logic             o_push,
    output t_job             o_job,
    input  wire logic        i_full
);
    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_CLS  = 3'd2;
    localparam logic [2:0] F_J1   = 3'd3;
    localparam logic [2:0] F_J2   = 3'd4;
    localparam logic [2:0] F_J3   = 3'd5;
    localparam logic [2:0] F_J4   = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [1:0]             r_cnt;
    logic [CW-1:0]          r_x, r_y, r_z;
    logic                   r_last;
    logic signed [DW-1:0]   r_acc;
    logic signed [49:0]     r_prod;
    logic                   r_c1, r_k2, r_c3;
    logic [CW-1:0]          r_fx, r_fy, r_fz, r_px, r_py, r_pz;
    logic signed [DW-1:0]   r_fd, r_pd;
    logic                   r_have;

    logic signed [17:0]     w_n;
    logic signed [31:0]     w_v;
    logic signed [49:0]     w_prod;
    logic signed [DW-1:0]   w_fd;
    logic [CW-1:0]          w_fx, w_fy, w_fz;
    logic                   w_mark;
    logic                   w_done;

    assign o_ready = (r_state == F_IDLE);

    always_comb begin
        case (r_cnt)
            2'd0:    begin w_n = i_cfg.nx; w_v = $signed(r_x); end
            2'd1:    begin w_n = i_cfg.ny; w_v = $signed(r_y); end
            default: begin w_n = i_cfg.nz; w_v = $signed(r_z); end
        endcase
    end
    assign w_prod = w_n * w_v;

    // a single-vertex polygon closes on itself
    assign w_fd = r_have ? r_fd : r_acc;
    assign w_fx = r_have ? r_fx : r_x;
    assign w_fy = r_have ? r_fy : r_y;
    assign w_fz = r_have ? r_fz : r_z;
    assign w_mark = r_last && !(r_c1 || r_k2 || r_c3);

    function automatic t_job mk_cross(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                                      input logic [CW-1:0] az, input logic signed [DW-1:0] da,
                                      input logic [CW-1:0] bx, input logic [CW-1:0] by,
                                      input logic [CW-1:0] bz, input logic signed [DW-1:0] db);
        t_job j;
        j.kind = JOB_CROSS;
        j.eop  = 1'b0;
        if (f_pos(da)) begin
            j.px = ax; j.py = ay; j.pz = az;
            j.qx = bx; j.qy = by; j.qz = bz;
            j.num = f_mag(da);
        end else begin
            j.px = bx; j.py = by; j.pz = bz;
            j.qx = ax; j.qy = ay; j.qz = az;
            j.num = f_mag(db);
        end
        j.den = NW'(f_mag(da)) + NW'(f_mag(db));
        return j;
    endfunction

    always_comb begin
        o_push = 1'b0;
        o_job  = '0;
        w_done = 1'b1;
        case (r_state)
            F_J1: begin
                o_job     = mk_cross(r_px, r_py, r_pz, r_pd, r_x, r_y, r_z, r_acc);
                o_job.eop = r_last && !r_k2 && !r_c3;
                o_push    = r_c1 && !i_full;
                w_done    = !r_c1 || !i_full;
            end
            F_J2: begin
                o_job.kind = JOB_VERT;
                o_job.px   = r_x;
                o_job.py   = r_y;
                o_job.pz   = r_z;
                o_job.eop  = r_last && !r_c3;
                o_push     = r_k2 && !i_full;
                w_done     = !r_k2 || !i_full;
            end
            F_J3: begin
                o_job     = mk_cross(r_x, r_y, r_z, r_acc, w_fx, w_fy, w_fz, w_fd);
                o_job.eop = 1'b1;
                o_push    = r_c3 && !i_full;
                w_done    = !r_c3 || !i_full;
            end
            F_J4: begin
                o_job.kind = JOB_MARK;
                o_job.eop  = 1'b1;
                o_push     = w_mark && !i_full;
                w_done     = !w_mark || !i_full;
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_valid) n_state = F_MUL;
            F_MUL:   if (r_cnt == 2'd3) n_state = F_CLS;
            F_CLS:   n_state = F_J1;
            F_J1:    if (w_done) n_state = F_J2;
            F_J2:    if (w_done) n_state = F_J3;
            F_J3:    if (w_done) n_state = F_J4;
            F_J4:    if (w_done) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
            r_have  <= 1'b0;
            r_fx <= '0; r_fy <= '0; r_fz <= '0; r_fd <= '0;
            r_px <= '0; r_py <= '0; r_pz <= '0; r_pd <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_IDLE && i_valid) begin
                r_x    <= i_vertex_x;
                r_y    <= i_vertex_y;
                r_z    <= i_vertex_z;
                r_last <= i_last_vertex;
                r_cnt  <= '0;
            end
            if (r_state == F_MUL) begin
                r_cnt  <= r_cnt + 1'b1;
                r_prod <= w_prod;
                if (r_cnt == 2'd0) begin
                    r_acc <= $signed({{(DW-48){i_cfg.off[31]}}, i_cfg.off, 16'h0000});
                end else begin
                    r_acc <= r_acc + DW'(r_prod);
                end
            end
            if (r_state == F_CLS) begin
                r_c1 <= r_have && f_cross(r_pd, r_acc, i_cfg.eps);
                r_k2 <= f_on(r_acc, i_cfg.eps) || f_pos(r_acc);
                r_c3 <= r_last && f_cross(r_acc, w_fd, i_cfg.eps);
            end
            if (r_state == F_J4 && w_done) begin
                r_px <= r_x; r_py <= r_y; r_pz <= r_z; r_pd <= r_acc;
                if (!r_have) begin
                    r_fx <= r_x; r_fy <= r_y; r_fz <= r_z; r_fd <= r_acc;
                end
                r_have <= !r_last;
            end
        end
    end
endmodule
`default_nettype wire

[sv/ppc_back.sv]
// ----------------------------------------------------------------------------
// ppc_back
// runs queued jobs: restoring divide, interpolation, output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "polygon_plane_clipper_assert.svh"
module ppc_back
    import ppc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_out_x,
    output logic [31:0]      o_out_y,
    output logic [31:0]      o_out_z,
    output logic             o_out_valid,
    output logic             o_end_of_polygon
);
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIV  = 3'd1;
    localparam logic [2:0] B_MUL  = 3'd2;
    localparam logic [2:0] B_ADD  = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;
    localparam logic [4:0] DIV_LAST = 5'(KW - 1);

    logic [2:0]        r_state;
    t_job              r_job;
    logic [4:0]        r_cnt;
    logic [NW-1:0]     r_rem;
    logic [KW-1:0]     r_k;
    logic [1:0]        r_c;
    logic [48:0]       r_hi, r_lo;
    logic              r_neg;
    logic [CW-1:0]     r_res [3];
    logic              r_rv;
    logic              r_ov;

    logic [NW:0]       w_t;
    logic [CW-1:0]     w_p, w_q;
    logic signed [32:0] w_delta;
    logic [32:0]       w_a;
    logic [49:0]       w_sum;
    logic              w_load;

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = r_ov;
    assign w_load  = (r_state == B_OUT) && (!r_ov || i_ready);
    assign w_t     = {r_rem, 1'b0};

    always_comb begin
        case (r_c)
            2'd0:    begin w_p = r_job.px; w_q = r_job.qx; end
            2'd1:    begin w_p = r_job.py; w_q = r_job.qy; end
            default: begin w_p = r_job.pz; w_q = r_job.qz; end
        endcase
    end
    assign w_delta = $signed({w_q[CW-1], w_q}) - $signed({w_p[CW-1], w_p});
    assign w_a     = w_delta[32] ? 33'(-w_delta) : 33'(w_delta);
    // low partial product is truncated before the sum
    assign w_sum   = 50'(r_hi) + 50'(r_lo >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_job <= i_job;
                        r_rem <= NW'(i_job.num);
                        r_k   <= '0;
                        r_cnt <= '0;
                        r_c   <= '0;
                        r_rv  <= (i_job.kind != JOB_MARK);
                        if (i_job.kind == JOB_CROSS) begin
                            r_state <= B_DIV;
                        end else begin
                            if (i_job.kind == JOB_VERT) begin
                                r_res[0] <= i_job.px;
                                r_res[1] <= i_job.py;
                                r_res[2] <= i_job.pz;
                            end else begin
                                r_res[0] <= '0;
                                r_res[1] <= '0;
                                r_res[2] <= '0;
                            end
                            r_state <= B_OUT;
                        end
                    end
                end
                B_DIV: begin
                    if (w_t >= (NW+1)'(r_job.den)) begin
                        r_rem <= NW'(w_t - (NW+1)'(r_job.den));
                        r_k   <= {r_k[KW-2:0], 1'b1};
                    end else begin
                        r_rem <= NW'(w_t);
                        r_k   <= {r_k[KW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_hi    <= 49'(w_a) * 49'(r_k[31:16]);
                    r_lo    <= 49'(w_a) * 49'(r_k[15:0]);
                    r_neg   <= w_delta[32];
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    r_res[r_c] <= r_neg ? (w_p - w_sum[47:16]) : (w_p + w_sum[47:16]);
                    if (r_c == 2'd2) begin
                        r_state <= B_OUT;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= B_MUL;
                    end
                end
                B_OUT: begin
                    if (w_load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_out_x          <= r_res[0];
            o_out_y          <= r_res[1];
            o_out_z          <= r_res[2];
            o_out_valid      <= r_rv;
            o_end_of_polygon <= r_job.eop;
        end
    end

    `PPC_ASSERT_IMPL(a_marker_ends, o_valid && !o_out_valid, o_end_of_polygon, "empty marker without end flag")
    `PPC_ASSERT_NEXT(a_div_done, (r_state == B_DIV) && (r_cnt == DIV_LAST), r_state == B_MUL, "divide did not finish after full count")
    `PPC_ASSERT_NEXT(a_out_load, w_load, r_ov && (r_state == B_IDLE), "result not loaded into output register")
endmodule
`default_nettype wire

[sv/polygon_plane_clipper.sv]
// path: a kept vertex goes through the classifier, the job queue and the output register; a
// crossing point also goes through the 32-step divider and 3 x 2 interpolation steps
// the front end takes a new vertex only when idle, after all jobs of the last one are queued,
// and stalls while the queue is full; with crossings the single shared divider bounds the rate
// (up to two crossings for the last vertex of a polygon, at most one for any other vertex)
// reset: synchronous active low, clears control state and loads the default plane z > 0
// ----------------------------------------------------------------------------
// polygon_plane_clipper
// single-plane convex polygon clipper with config registers and job queue
// ----------------------------------------------------------------------------
`default_nettype none
module polygon_plane_clipper
    import ppc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_vertex_x,
    input  wire logic [31:0] i_vertex_y,
    input  wire logic [31:0] i_vertex_z,
    input  wire logic        i_last_vertex,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_out_x,
    output logic [31:0]      o_out_y,
    output logic [31:0]      o_out_z,
    output logic             o_out_valid,
    output logic             o_end_of_polygon
);
    t_cfg  r_cfg;
    t_job  w_qin, w_qout;
    logic  w_push, w_full, w_pop, w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nx  <= '0;
            r_cfg.ny  <= '0;
            r_cfg.nz  <= 18'sd65536;
            r_cfg.off <= '0;
            r_cfg.eps <= 16'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_NX:  r_cfg.nx  <= i_cfg_data[17:0];
                CFG_NY:  r_cfg.ny  <= i_cfg_data[17:0];
                CFG_NZ:  r_cfg.nz  <= i_cfg_data[17:0];
                CFG_OFF: r_cfg.off <= i_cfg_data;
                CFG_EPS: r_cfg.eps <= i_cfg_data[15:0];
                default: r_cfg     <= r_cfg;
            endcase
        end
    end

    ppc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_vertex_z    (i_vertex_z),
        .i_last_vertex (i_last_vertex),
        .o_push        (w_push),
        .o_job         (w_qin),
        .i_full        (w_full)
    );

    ppc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_qout)
    );

    ppc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (w_empty),
        .i_job            (w_qout),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_x          (o_out_x),
        .o_out_y          (o_out_y),
        .o_out_z          (o_out_z),
        .o_out_valid      (o_out_valid),
        .o_end_of_polygon (o_end_of_polygon)
    );
endmodule
`default_nettype wire
